// ===== rtl/nco_pkg.sv =====
// Shared constants, types and quarter-wave table generator for the oscillator.
`default_nettype none

package nco_pkg;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int BLEN_W     = 13;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 2'd3;

  localparam logic [BLEN_W-1:0] BLOCK_LENGTH_RST = 13'd256;

  // pi/2 in Q30 and unity in Q30 for the table polynomial.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

  // Per-beat control flags that travel alongside the phase.
  typedef struct packed {
    logic cplx;
    logic last;
  } nco_ctl_t;

  // Quarter-wave sine magnitude for entry j of a table with 2^addr_bits steps
  // per quarter turn, evaluated only at elaboration.
  function automatic logic [63:0] quarter_entry(input logic [63:0] j,
                                                input int addr_bits,
                                                input int out_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] m;
    logic [63:0] fs;
    begin
      fs = (64'd1 << (out_bits - 1)) - 64'd1;
      x  = (j * HALF_PI_Q30) >> addr_bits;
      x2 = (x * x) >> 30;
      r  = Q30_ONE;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd110;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd72;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd42;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd20;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd6;
      s  = (x * r) >> 30;
      m  = (s * fs + (64'd1 << 29)) >> 30;
      return (m > fs) ? fs : m;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/numerically_controlled_oscillator_unit.sv =====
// Top level of the phase-accumulator oscillator: configuration, pipeline and output register.
`default_nettype none

// Usage notes.
// The input channel (in_valid, in_stall, in_restart) carries one beat per requested
// sample; in_restart reloads the phase from start_phase and restarts the block count
// before that sample is made. The output channel (out_valid, out_stall) returns one
// beat per input beat: real_part holds the sine in real mode or the cosine in complex
// mode, imag_part the sine in complex mode or zero, and block_end flags the last
// sample of each block of block_length samples.
// An accepted sample passes in order through a phase register, the registered read
// of the quarter-wave table and the output register. Throughput is one sample per
// clock while the receiver does not stall, set by the phase add and the two read
// ports of the table, which give sine and cosine together.
// When the receiver stalls, each stage holds its beat only if the stage after it is
// full, so bubbles close up and input is still taken until the pipeline is full.
// The configuration port writes one register per enabled cycle and should be used
// only while no samples are in flight.
// Synchronous reset empties the pipeline, clears the phase and block count and
// returns the registers to real mode, zero step, zero start phase and a block of 256.
module numerically_controlled_oscillator_unit #(
  parameter int PHASE_BITS      = 32,
  parameter int OUT_BITS        = 16,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int MAX_BLOCK       = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [nco_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [nco_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_restart,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [OUT_BITS-1:0]               out_real_part,
  output logic signed [OUT_BITS-1:0]               out_imag_part,
  output logic                                     out_block_end
);

  localparam logic signed [OUT_BITS-1:0] MOST_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

  // Configuration registers.
  logic                            cplx_r;
  logic [nco_pkg::CFG_DATA_W-1:0]  step_r;
  logic [nco_pkg::CFG_DATA_W-1:0]  start_r;
  logic [nco_pkg::BLEN_W-1:0]      blen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cplx_r  <= 1'b0;
      step_r  <= '0;
      start_r <= '0;
      blen_r  <= nco_pkg::BLOCK_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nco_pkg::CFG_COMPLEX_MODE: cplx_r  <= cfg_wdata[0];
        nco_pkg::CFG_PHASE_STEP:   step_r  <= cfg_wdata;
        nco_pkg::CFG_START_PHASE:  start_r <= cfg_wdata;
        nco_pkg::CFG_BLOCK_LENGTH: blen_r  <= cfg_wdata[nco_pkg::BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Ready chain: a stage may load when it is empty or the stage after it moves on.
  logic a_v;
  logic a_rdy;
  logic b_rdy;
  logic c_rdy;
  logic b_v_r;
  logic in_accept;

  assign c_rdy     = !out_valid || !out_stall;
  assign b_rdy     = !b_v_r || c_rdy;
  assign a_rdy     = !a_v || b_rdy;
  assign in_stall  = !a_rdy;
  assign in_accept = in_valid && a_rdy;

  // Stage A: phase accumulator and block counter.
  logic [PHASE_BITS-1:0] a_ph;
  nco_pkg::nco_ctl_t     a_ctl;

  nco_acc #(
    .PHASE_BITS (PHASE_BITS),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (a_rdy),
    .take      (in_accept),
    .restart   (in_restart),
    .cfg_cplx  (cplx_r),
    .cfg_step  (step_r),
    .cfg_start (start_r),
    .cfg_blen  (blen_r),
    .a_v_r     (a_v),
    .a_ph_r    (a_ph),
    .a_ctl_r   (a_ctl)
  );

  // Stage B: table read for sine and cosine of the truncated phase.
  logic [OUT_BITS-2:0] sin_mag;
  logic [OUT_BITS-2:0] cos_mag;
  logic                sin_neg;
  logic                cos_neg;
  nco_pkg::nco_ctl_t   b_ctl_r;
  logic                b_en;

  assign b_en = b_rdy && a_v;

  nco_sine #(
    .ADDR_BITS (TABLE_ADDR_BITS),
    .OUT_BITS  (OUT_BITS)
  ) u_sine (
    .clk       (clk),
    .en        (b_en),
    .ang       (a_ph[PHASE_BITS-1 -: TABLE_ADDR_BITS+2]),
    .sin_mag_r (sin_mag),
    .sin_neg_r (sin_neg),
    .cos_mag_r (cos_mag),
    .cos_neg_r (cos_neg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_rdy) begin
      b_v_r <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_ctl_r <= a_ctl;
    end
  end

  // Stage C: apply the quadrant sign and select the outputs for the mode.
  logic [OUT_BITS-1:0] sin_pos;
  logic [OUT_BITS-1:0] cos_pos;
  logic [OUT_BITS-1:0] sin_val;
  logic [OUT_BITS-1:0] cos_val;
  logic                out_cplx_r;
  logic                c_en;

  assign c_en = c_rdy && b_v_r;

  always_comb begin
    sin_pos = {1'b0, sin_mag};
    cos_pos = {1'b0, cos_mag};
    sin_val = sin_neg ? (-sin_pos) : sin_pos;
    cos_val = cos_neg ? (-cos_pos) : cos_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (c_rdy) begin
      out_valid <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_en) begin
      out_real_part <= b_ctl_r.cplx ? cos_val : sin_val;
      out_imag_part <= b_ctl_r.cplx ? sin_val : '0;
      out_block_end <= b_ctl_r.last;
      out_cplx_r    <= b_ctl_r.cplx;
    end
  end

`ifndef ASSERT_OFF
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> a_v)
    else $error("accepted beat did not reach the phase stage");

  a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
    a_v && !b_rdy |=> a_v && $stable(a_ph))
    else $error("blocked phase stage lost or changed its beat");

  a_real_imag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cplx_r |-> out_imag_part == '0)
    else $error("imaginary part not zero in real mode");

  a_no_most_negative: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_real_part != MOST_NEG) && (out_imag_part != MOST_NEG))
    else $error("sample outside symmetric full scale");
`endif

endmodule

`default_nettype wire

// ===== rtl/nco_acc.sv =====
// Phase accumulator and block counter; registers the phase of each accepted sample.
`default_nettype none

module nco_acc #(
  parameter int PHASE_BITS = 32,
  parameter int MAX_BLOCK  = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          ld,
  input  wire logic                          take,
  input  wire logic                          restart,
  input  wire logic                          cfg_cplx,
  input  wire logic [nco_pkg::CFG_DATA_W-1:0] cfg_step,
  input  wire logic [nco_pkg::CFG_DATA_W-1:0] cfg_start,
  input  wire logic [nco_pkg::BLEN_W-1:0]     cfg_blen,
  output logic                               a_v_r,
  output logic [PHASE_BITS-1:0]              a_ph_r,
  output nco_pkg::nco_ctl_t                  a_ctl_r
);

  localparam int CNT_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int LEN_W = $clog2(MAX_BLOCK + 1);

  logic [PHASE_BITS-1:0] acc_r;
  logic [PHASE_BITS-1:0] acc_nxt;
  logic [PHASE_BITS-1:0] base;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic [CNT_W-1:0]      cnt_base;
  logic [LEN_W-1:0]      cnt_inc;
  logic [LEN_W-1:0]      len_eff;
  logic [31:0]           blen_w;
  logic                  last;

  always_comb begin
    base     = restart ? PHASE_BITS'(cfg_start) : acc_r;
    acc_nxt  = base + PHASE_BITS'(cfg_step);
    cnt_base = restart ? '0 : cnt_r;

    blen_w = 32'(cfg_blen);
    if (blen_w == 32'd0) begin
      len_eff = LEN_W'(1);
    end else if (blen_w > 32'(MAX_BLOCK)) begin
      len_eff = LEN_W'(MAX_BLOCK);
    end else begin
      len_eff = LEN_W'(blen_w);
    end

    cnt_inc = LEN_W'(cnt_base) + LEN_W'(1);
    last    = (cnt_inc >= len_eff);
    cnt_nxt = last ? '0 : CNT_W'(cnt_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      a_v_r <= 1'b0;
    end else begin
      if (take) begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_nxt;
      end
      if (ld) begin
        a_v_r <= take;
      end
    end
  end

  // Complex mode looks up the stepped phase, real mode the phase before the step.
  always_ff @(posedge clk) begin
    if (take) begin
      a_ph_r       <= cfg_cplx ? acc_nxt : base;
      a_ctl_r.cplx <= cfg_cplx;
      a_ctl_r.last <= last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nco_sine.sv =====
// Quarter-wave sine memory with two registered read ports for sine and cosine.
`default_nettype none

module nco_sine #(
  parameter int ADDR_BITS = 10,
  parameter int OUT_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [ADDR_BITS+1:0] ang,
  output logic      [OUT_BITS-2:0]  sin_mag_r,
  output logic                      sin_neg_r,
  output logic      [OUT_BITS-2:0]  cos_mag_r,
  output logic                      cos_neg_r
);

  localparam int DEPTH = (1 << ADDR_BITS) + 1;
  localparam logic [ADDR_BITS:0] IDX_N = {1'b1, {ADDR_BITS{1'b0}}};

  typedef logic [OUT_BITS-2:0] mag_t;
  typedef mag_t tab_t [DEPTH];

  function automatic tab_t build_tab();
    tab_t t;
    begin
      for (int j = 0; j < DEPTH; j++) begin
        t[j] = mag_t'(nco_pkg::quarter_entry(64'(j), ADDR_BITS, OUT_BITS));
      end
      return t;
    end
  endfunction

  localparam tab_t QTAB = build_tab();

  logic [1:0]           q_s;
  logic [1:0]           q_c;
  logic [ADDR_BITS-1:0] k;
  logic [ADDR_BITS:0]   a_s;
  logic [ADDR_BITS:0]   a_c;

  // Odd quadrants read the table backwards; the cosine is one quadrant ahead.
  always_comb begin
    q_s = ang[ADDR_BITS+1:ADDR_BITS];
    q_c = q_s + 2'd1;
    k   = ang[ADDR_BITS-1:0];
    a_s = q_s[0] ? (IDX_N - {1'b0, k}) : {1'b0, k};
    a_c = q_c[0] ? (IDX_N - {1'b0, k}) : {1'b0, k};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_mag_r <= QTAB[a_s];
      cos_mag_r <= QTAB[a_c];
      sin_neg_r <= q_s[1];
      cos_neg_r <= q_c[1];
    end
  end

endmodule

`default_nettype wire
